// ----- src/dsp_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_pkg: shared constants for the shortest-path engine
// Sizes, fixed-point constants and register indexes.
// ----------------------------------------------------------------------------
package dsp_pkg;
	localparam int MaxVertices = 64;
	localparam int MaxEdges    = 256;
	localparam int VW = $clog2(MaxVertices);
	localparam int EW = $clog2(MaxEdges);
	localparam int CW = EW + 1;
	localparam logic [23:0] DistMax    = 24'hFFFFFF;
	localparam logic [15:0] UnitWeight = 16'h0100;
	localparam logic RegWeighted = 1'b0;
	localparam logic RegDirected = 1'b1;
endpackage
`default_nettype wire

// ----- src/dsp_edge_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_edge_ram: edge table memory
// One write port, one registered read port; entry is {src, dst, weight}.
// ----------------------------------------------------------------------------
module dsp_edge_ram (
	input  wire logic                       clk,
	input  wire logic                       we,
	input  wire logic [dsp_pkg::EW-1:0]     waddr,
	input  wire logic [2*dsp_pkg::VW+15:0]  wdata,
	input  wire logic [dsp_pkg::EW-1:0]     raddr,
	output logic      [2*dsp_pkg::VW+15:0]  rdata
);
	logic [2*dsp_pkg::VW+15:0] mem [dsp_pkg::MaxEdges];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ----- src/dijkstra_shortest_paths.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dijkstra_shortest_paths: Dijkstra engine over a bounded edge table
// Loads edges, then on a run emits distance and predecessor per vertex.
// ----------------------------------------------------------------------------
// Edge items scan the edge table once for a duplicate (one memory read per
// cycle), then decide and write the entry in DUPCHK and, when undirected,
// write the reverse entry in WRITE2. A run resets its per-vertex flags, then
// for each finalized vertex runs the minimum search (one vertex memory read
// per cycle), finalizes the winner in SWAIT and relaxes its edges (an edge
// read is issued in RELAX and issue is held in RLAST while the target
// distance is read, then the distance memory is read-modify-written under
// an interlock), and finally streams one result per present vertex,
// skipping absent vertices and holding each result while the output is
// stalled. Input is held off the whole time.
// Distances and predecessors live in a 64-entry memory; the reached, sat and
// finalized flags are flip-flops reset at run start (reached: start only).
// ----------------------------------------------------------------------------
module dijkstra_shortest_paths (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic        cfg_data,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [39:0] s_tdata,  // src[5:0], dst[11:6], weight[27:12], start[33:28]
	input  wire logic        s_tuser,  // mode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,  // vertex[5:0], reachable[6], distance[30:7],
	                                   // predecessor[36:31], overflow[37]
	output logic             m_tlast
);
	localparam int VW = dsp_pkg::VW;
	localparam int EW = dsp_pkg::EW;
	localparam int CW = dsp_pkg::CW;
	localparam logic [dsp_pkg::MaxVertices-1:0] VOne =
		{{(dsp_pkg::MaxVertices-1){1'b0}}, 1'b1};

	typedef enum logic [3:0] {
		IDLE, DUPSCAN, DUPCHK, WRITE2, CLR, SEARCH, SWAIT, RELAX, RLAST, OUTRD, OUTGO
	} st_t;

	st_t st_q;
	logic weighted_q, directed_q;
	logic [CW-1:0] ecnt_q;
	logic dropped_q;
	logic [dsp_pkg::MaxVertices-1:0] present_q, reached_q, fin_q, sat_q;

	// current item
	logic [VW-1:0] a_q, b_q, start_q;
	logic [15:0] w_q;
	logic dup_q;

	// edge memory
	logic e_we;
	logic [EW-1:0] e_waddr, e_raddr;
	logic [2*VW+15:0] e_wdata, e_rdata;
	logic [CW-1:0] idx_q;
	logic rv_s1; // edge read valid

	dsp_edge_ram u_ram (
		.clk(clk), .we(e_we), .waddr(e_waddr), .wdata(e_wdata),
		.raddr(e_raddr), .rdata(e_rdata)
	);

	// vertex memory: {dist, pred}
	logic [23+VW:0] vmem [dsp_pkg::MaxVertices];
	logic [23+VW:0] vrd;
	logic [VW-1:0] vraddr;
	logic vwe;
	logic [VW-1:0] vwaddr;
	logic [23+VW:0] vwdata;
	always_ff @(posedge clk) begin
		if (vwe) vmem[vwaddr] <= vwdata;
		vrd <= vmem[vraddr];
	end

	// search state
	logic [VW:0] sv_q;           // vertex being issued
	logic [VW-1:0] sv_s1;
	logic sval_s1;
	logic found_q;
	logic [VW-1:0] u_q;
	logic [23:0] ud_q;
	logic [VW-1:0] t_s1;         // relax: target whose dist read in flight
	logic [24:0] cand_s1;
	logic tv_s1;
	logic ovf_q;
	logic [VW-1:0] ov_s1;
	logic ovv_s1;

	wire [VW-1:0] in_src = s_tdata[VW-1:0];
	wire [VW-1:0] in_dst = s_tdata[2*VW-1:VW];
	wire [15:0]   in_w   = s_tdata[2*VW+15:2*VW];
	wire [VW-1:0] in_st  = s_tdata[2*VW+21:2*VW+16];

	wire [VW-1:0] r_src = e_rdata[2*VW+15:VW+16];
	wire [VW-1:0] r_dst = e_rdata[VW+15:16];
	wire [15:0]   r_w   = e_rdata[15:0];

	wire [CW-1:0] need = directed_q ? CW'(1) : CW'(2);
	wire [24:0] cand_c = {1'b0, ud_q} + {9'd0, r_w};

	assign s_tready = (st_q == IDLE);

	// memory ports by state
	always_comb begin
		e_raddr = idx_q[EW-1:0];
		e_we    = 1'b0;
		e_waddr = ecnt_q[EW-1:0];
		e_wdata = {a_q, b_q, w_q};
		if (st_q == DUPCHK && !dup_q && (ecnt_q + need <= CW'(dsp_pkg::MaxEdges)))
			e_we = 1'b1;
		if (st_q == WRITE2) begin
			e_we = 1'b1;
			e_wdata = {b_q, a_q, w_q};
		end
		vraddr = sv_q[VW-1:0];
		if (st_q == RELAX || st_q == RLAST) vraddr = r_dst;
		if (st_q == OUTRD || st_q == OUTGO) vraddr = sv_q[VW-1:0];
		vwe = 1'b0;
		vwaddr = t_s1;
		vwdata = {cand_s1[23:0], u_q};
		if (st_q == CLR) begin
			vwe = 1'b1;
			vwaddr = start_q;
			vwdata = {24'd0, start_q};
		end else if (tv_s1 && (!reached_q[t_s1] || vrd[23+VW:VW] > cand_s1[23:0])) begin
			vwe = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= IDLE;
			weighted_q <= 1'b1;
			directed_q <= 1'b0;
			ecnt_q <= '0;
			dropped_q <= 1'b0;
			present_q <= '0;
			reached_q <= '0;
			fin_q <= '0;
			sat_q <= '0;
			m_tvalid <= 1'b0;
			m_tlast <= 1'b0;
			rv_s1 <= 1'b0;
			sval_s1 <= 1'b0;
			tv_s1 <= 1'b0;
			ovv_s1 <= 1'b0;
			idx_q <= '0;
			sv_q <= '0;
			found_q <= 1'b0;
			dup_q <= 1'b0;
			ovf_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == dsp_pkg::RegWeighted) weighted_q <= cfg_data;
				else weighted_q <= weighted_q;
				if (cfg_index == dsp_pkg::RegDirected) directed_q <= cfg_data;
			end
			// read-valid flags: set in the cycle after each issued read
			rv_s1 <= ((st_q == DUPSCAN) || (st_q == RELAX)) && (idx_q < ecnt_q);
			sval_s1 <= (st_q == SEARCH) && (sv_q < (VW+1)'(dsp_pkg::MaxVertices));
			tv_s1 <= (st_q == RLAST) && rv_s1 && (r_src == u_q);
			ovv_s1 <= (st_q == OUTRD) && (sv_q != (VW+1)'(dsp_pkg::MaxVertices)) &&
			          present_q[sv_q[VW-1:0]];
			// relax write-back side effects
			if (vwe && st_q != CLR) begin
				reached_q[t_s1] <= 1'b1;
				sat_q[t_s1] <= cand_s1[24];
			end
			case (st_q)
				IDLE: begin
					if (s_tvalid) begin
						a_q <= in_src;
						b_q <= in_dst;
						w_q <= weighted_q ? in_w : dsp_pkg::UnitWeight;
						start_q <= in_st;
						idx_q <= '0;
						dup_q <= 1'b0;
						st_q <= s_tuser ? CLR : DUPSCAN;
					end
				end
				DUPSCAN: begin
					// issue reads 0..ecnt-1, check each in the cycle after
					if (rv_s1 && r_src == a_q && r_dst == b_q) dup_q <= 1'b1;
					if (idx_q < ecnt_q) begin
						idx_q <= idx_q + CW'(1);
					end else if (!rv_s1) begin
						st_q <= DUPCHK;
					end
				end
				DUPCHK: begin
					if (!dup_q) begin
						if (ecnt_q + need > CW'(dsp_pkg::MaxEdges)) begin
							dropped_q <= 1'b1;
							st_q <= IDLE;
						end else begin
							ecnt_q <= ecnt_q + CW'(1);
							present_q <= present_q | (VOne << a_q) | (VOne << b_q);
							st_q <= directed_q ? IDLE : WRITE2;
						end
					end else begin
						st_q <= IDLE;
					end
				end
				WRITE2: begin
					ecnt_q <= ecnt_q + CW'(1);
					st_q <= IDLE;
				end
				CLR: begin
					reached_q <= VOne << start_q;
					fin_q <= '0;
					sat_q <= '0;
					sv_q <= '0;
					found_q <= 1'b0;
					st_q <= SEARCH;
				end
				SEARCH: begin
					if (sval_s1 && reached_q[sv_s1] && !fin_q[sv_s1] &&
					    (!found_q || vrd[23+VW:VW] < ud_q)) begin
						found_q <= 1'b1;
						u_q <= sv_s1;
						ud_q <= vrd[23+VW:VW];
					end
					if (sv_q < (VW+1)'(dsp_pkg::MaxVertices)) begin
						sv_s1 <= sv_q[VW-1:0];
						sv_q <= sv_q + (VW+1)'(1);
					end else if (!sval_s1) begin
						st_q <= SWAIT;
					end
				end
				SWAIT: begin
					if (found_q) begin
						fin_q[u_q] <= 1'b1;
						idx_q <= '0;
						st_q <= RELAX;
					end else begin
						// overflow from dropped edges or saturated reachable present vertices
						ovf_q <= dropped_q || ((present_q & reached_q & sat_q) != '0);
						sv_q <= '0;
						st_q <= OUTRD;
					end
				end
				RELAX: begin
					// issue edge reads; dist read of target follows rdata
					if (idx_q < ecnt_q) begin
						idx_q <= idx_q + CW'(1);
						st_q <= RLAST;
					end else if (!rv_s1 && !tv_s1) begin
						sv_q <= '0;
						found_q <= 1'b0;
						st_q <= SEARCH;
					end
				end
				RLAST: begin
					// edge data valid: read target distance, hold issue in this state
					if (rv_s1 && r_src == u_q) begin
						t_s1 <= r_dst;
						cand_s1 <= cand_c[24] ? {1'b1, dsp_pkg::DistMax} : cand_c;
					end
					st_q <= RELAX;
				end
				OUTRD: begin
					// skip absent vertices
					if (sv_q == (VW+1)'(dsp_pkg::MaxVertices)) begin
						st_q <= IDLE;
					end else if (present_q[sv_q[VW-1:0]]) begin
						ov_s1 <= sv_q[VW-1:0];
						st_q <= OUTGO;
					end else begin
						sv_q <= sv_q + (VW+1)'(1);
					end
				end
				OUTGO: begin
					if (ovv_s1) begin
						m_tvalid <= 1'b1;
						m_tdata <= {2'b0, ovf_q,
							reached_q[ov_s1] ? vrd[VW-1:0] : {VW{1'b0}},
							reached_q[ov_s1] ? vrd[23+VW:VW] : 24'd0,
							reached_q[ov_s1], ov_s1};
						m_tlast <= (sv_q == (VW+1)'(dsp_pkg::MaxVertices-1)) ||
						           ((present_q >> (sv_q + (VW+1)'(1))) == '0);
					end else if (m_tvalid && m_tready) begin
						m_tvalid <= 1'b0;
						sv_q <= sv_q + (VW+1)'(1);
						st_q <= m_tlast ? IDLE : OUTRD;
					end
				end
				default: st_q <= IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- src/dsp_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dsp_checker: port-level checks for the shortest-path engine
// Watches the stream ports over time.
// ----------------------------------------------------------------------------
module dsp_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [39:0] m_tdata,
	input wire logic        m_tlast
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output not held");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready)
		else $error("input open during result output");
	a_unreach: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[6] |-> m_tdata[36:7] == '0)
		else $error("unreachable result carries data");
endmodule

bind dijkstra_shortest_paths dsp_checker u_chk (
	.clk(clk), .arst_n(arst_n), .s_tready(s_tready), .m_tvalid(m_tvalid),
	.m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
);
`default_nettype wire

// ----- tb/sv/dijkstra_shortest_paths_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dijkstra_shortest_paths_tb: self-checking bench for the shortest-path engine
// Loads edge tables through the input stream, launches runs and compares every
// per-vertex result against an in-bench Dijkstra predictor or a fixed expected
// entry, under random source gaps, sink stalls and register settings.
// ----------------------------------------------------------------------------
module dijkstra_shortest_paths_tb;

	localparam int DrainCycles = 700;     // long enough for the worst edge scan
	localparam int CycleLimit  = 4000000;

	typedef enum logic [1:0] {OP_EDGE, OP_RUN, OP_CFG} op_e;

	// one stimulus row: edge (a=src, b=dst, w), run (s), or register write (a=index, b=value)
	typedef struct {
		op_e         op;
		logic [5:0]  a;
		logic [5:0]  b;
		logic [15:0] w;
		logic [5:0]  s;
		bit          typed;     // result known at a glance: one vertex 0 entry
		bit          t_reach;
	} row_t;

	typedef struct packed {
		logic [5:0]  vertex;
		logic        reach;
		logic [23:0] distance;
		logic [5:0]  pred;
		logic        ovf;
		logic        last;
	} path_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = 1'b0;
	logic        cfg_data = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata = '0;   // src[5:0], dst[11:6], weight[27:12], start[33:28]
	logic        s_tuser = 1'b0; // mode
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;        // vertex[5:0], reachable[6], distance[30:7],
	                             // predecessor[36:31], overflow[37]
	logic        m_tlast;

	dijkstra_shortest_paths u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always #2 clk = ~clk;

	// shadow of the block's graph state and registers
	logic [5:0]  g_src [dsp_pkg::MaxEdges];
	logic [5:0]  g_dst [dsp_pkg::MaxEdges];
	logic [15:0] g_wt  [dsp_pkg::MaxEdges];
	int          g_count = 0;
	bit          g_present [dsp_pkg::MaxVertices];
	bit          g_dropped = 0;
	bit          g_weighted = 1;
	bit          g_directed = 0;

	path_t path_q[$];     // per-vertex results still owed by the block
	int    errors = 0;
	int    tx_idle_pct = 0;
	int    rx_stall_pct = 0;
	int    rx_hold = 0;
	longint cycles = 0;

	// Store one edge item the way the block does: skip duplicates, drop whole on full.
	function automatic void store_edge(logic [5:0] a, logic [5:0] b, logic [15:0] w);
		logic [15:0] wt;
		int need;
		wt = g_weighted ? w : dsp_pkg::UnitWeight;
		need = g_directed ? 1 : 2;
		for (int i = 0; i < g_count; i++)
			if (g_src[i] == a && g_dst[i] == b)
				return;
		if (g_count + need > dsp_pkg::MaxEdges) begin
			g_dropped = 1;
			return;
		end
		g_src[g_count] = a; g_dst[g_count] = b; g_wt[g_count] = wt; g_count++;
		if (!g_directed) begin
			g_src[g_count] = b; g_dst[g_count] = a; g_wt[g_count] = wt; g_count++;
		end
		g_present[a] = 1;
		g_present[b] = 1;
	endfunction

	// Dijkstra from s: least (distance, index) first, strict relaxation in table order.
	function automatic void shortest_paths(logic [5:0] s);
		logic [23:0] dist_v [dsp_pkg::MaxVertices];
		logic [5:0]  pred [dsp_pkg::MaxVertices];
		bit          reached [dsp_pkg::MaxVertices];
		bit          done [dsp_pkg::MaxVertices];
		bit          sat [dsp_pkg::MaxVertices];
		logic [24:0] cand;
		bit          sv, ovf;
		int          u, t, lastv;
		path_t       r;
		for (int v = 0; v < dsp_pkg::MaxVertices; v++) begin
			dist_v[v] = '0; pred[v] = '0; reached[v] = 0; done[v] = 0; sat[v] = 0;
		end
		reached[s] = 1;
		pred[s] = s;
		while (1) begin
			u = -1;
			for (int v = 0; v < dsp_pkg::MaxVertices; v++)
				if (reached[v] && !done[v] && (u < 0 || dist_v[v] < dist_v[u]))
					u = v;
			if (u < 0)
				break;
			done[u] = 1;
			for (int i = 0; i < g_count; i++) begin
				if (g_src[i] != u)
					continue;
				t = int'(g_dst[i]);
				cand = {1'b0, dist_v[u]} + {9'd0, g_wt[i]};
				sv = cand > {1'b0, dsp_pkg::DistMax};
				if (sv)
					cand = {1'b0, dsp_pkg::DistMax};
				if (!reached[t] || dist_v[t] > cand[23:0]) begin
					dist_v[t] = cand[23:0];
					pred[t] = 6'(u);
					reached[t] = 1;
					sat[t] = sv;
				end
			end
		end
		ovf = g_dropped;
		lastv = -1;
		for (int v = 0; v < dsp_pkg::MaxVertices; v++)
			if (g_present[v]) begin
				lastv = v;
				if (reached[v] && sat[v])
					ovf = 1;
			end
		for (int v = 0; v < dsp_pkg::MaxVertices; v++)
			if (g_present[v]) begin
				r.vertex   = 6'(v);
				r.reach    = reached[v];
				r.distance = reached[v] ? dist_v[v] : '0;
				r.pred     = reached[v] ? pred[v] : '0;
				r.ovf      = ovf;
				r.last     = (v == lastv);
				path_q = {path_q, r};
			end
	endfunction

	// Hold until every owed result has arrived, then let a trailing edge scan finish.
	task automatic wait_idle();
		while (path_q.size() != 0)
			@(negedge clk);
		repeat (DrainCycles) @(negedge clk);
	endtask

	task automatic write_reg(logic idx, logic val);
		wait_idle();
		cfg_we = 1'b1; cfg_index = idx; cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		if (idx == dsp_pkg::RegWeighted)
			g_weighted = val;
		else
			g_directed = val;
	endtask

	// Offer one item; called at a falling edge, returns at a falling edge.
	task automatic send_item(row_t it);
		path_t r;
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = (it.op == OP_RUN);
		s_tdata  = {6'd0, it.s, it.w, it.b, it.a};
		do @(posedge clk); while (!s_tready);
		// transfer accepted: update the shadow state now
		if (it.op == OP_EDGE)
			store_edge(it.a, it.b, it.w);
		else if (it.typed) begin
			r = '{vertex: 6'd0, reach: it.t_reach, distance: 24'd0, pred: 6'd0,
			      ovf: 1'b0, last: 1'b1};
			path_q = {path_q, r};
		end else
			shortest_paths(it.s);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	task automatic do_row(row_t it);
		if (it.op == OP_CFG)
			write_reg(it.a[0], it.b[0]);
		else
			send_item(it);
	endtask

	// Random item: mostly a small vertex cluster so runs find real paths.
	function automatic row_t rand_row(int run_pct);
		row_t it;
		it.op = ($urandom_range(99) < run_pct) ? OP_RUN : OP_EDGE;
		it.a = 6'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(11));
		it.b = 6'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(11));
		it.w = ($urandom_range(4) == 0) ? 16'($urandom_range(65535)) : 16'($urandom_range(1023));
		it.s = 6'(($urandom_range(3) == 0) ? $urandom_range(63) : $urandom_range(11));
		it.typed = 0;
		it.t_reach = 0;
		return it;
	endfunction

	// Sink side: stall at random, or hold off entirely while rx_hold counts down.
	always @(negedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_tready <= 1'b0;
		end else
			m_tready <= ($urandom_range(99) >= rx_stall_pct);
	end

	// Compare each transfer on the result stream with the oldest owed result.
	always @(posedge clk) begin
		path_t e, a;
		if (arst_n && m_tvalid && m_tready) begin
			a = '{vertex: m_tdata[5:0], reach: m_tdata[6], distance: m_tdata[30:7],
			      pred: m_tdata[36:31], ovf: m_tdata[37], last: m_tlast};
			if (path_q.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %p", $time, a);
			end else begin
				e = path_q.pop_front();
				if (a !== e) begin
					errors++;
					$display("%0t: mismatch expected %p actual %p", $time, e, a);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CycleLimit) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	row_t directed_rows[] = '{
		'{OP_RUN,  0,  0, 16'h0000, 0,  0, 0},  // no vertex present: no results
		'{OP_EDGE, 0,  0, 16'h1234, 0,  0, 0},  // self loop, stored both ways
		'{OP_RUN,  0,  0, 16'h0000, 0,  1, 1},  // start alone: distance 0, pred itself
		'{OP_RUN,  0,  0, 16'h0000, 63, 1, 0},  // start not present: all unreachable
		'{OP_EDGE, 0,  0, 16'h0000, 0,  0, 0},  // duplicate
		'{OP_EDGE, 0,  1, 16'hFFFF, 0,  0, 0},
		'{OP_EDGE, 1,  2, 16'h0000, 0,  0, 0},
		'{OP_EDGE, 2,  63, 16'hFFFF, 0, 0, 0},
		'{OP_EDGE, 63, 0, 16'h0001, 0,  0, 0},
		'{OP_EDGE, 1,  0, 16'h5555, 0,  0, 0},  // reverse already stored
		'{OP_RUN,  0,  0, 16'h0000, 0,  0, 0},
		'{OP_RUN,  0,  0, 16'h0000, 63, 0, 0},
		'{OP_CFG,  dsp_pkg::RegWeighted, 0, 16'h0000, 0, 0, 0},
		'{OP_EDGE, 3,  4, 16'hAAAA, 0,  0, 0},  // weight forced to one
		'{OP_EDGE, 4,  5, 16'hFFFF, 0,  0, 0},
		'{OP_RUN,  0,  0, 16'h0000, 5,  0, 0},
		'{OP_CFG,  dsp_pkg::RegDirected, 1, 16'h0000, 0, 0, 0},
		'{OP_CFG,  dsp_pkg::RegWeighted, 1, 16'h0000, 0, 0, 0},
		'{OP_EDGE, 5,  6, 16'h00FF, 0,  0, 0},
		'{OP_EDGE, 6,  5, 16'h0100, 0,  0, 0},  // opposite direction is new
		'{OP_EDGE, 7,  62, 16'hFF00, 0, 0, 0},
		'{OP_RUN,  0,  0, 16'h0000, 7,  0, 0},
		'{OP_RUN,  0,  0, 16'h0000, 62, 0, 0},
		'{OP_CFG,  dsp_pkg::RegDirected, 0, 16'h0000, 0, 0, 0}
	};

	initial begin
		int tx_mix[4] = '{0, 68, 0, 29};
		int rx_mix[4] = '{0, 0, 68, 29};
		int guard;
		row_t fill;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		foreach (directed_rows[i])
			do_row(directed_rows[i]);

		for (int ph = 0; ph < 4; ph++) begin
			write_reg(dsp_pkg::RegWeighted, 1'($urandom_range(1)));
			write_reg(dsp_pkg::RegDirected, 1'($urandom_range(1)));
			tx_idle_pct = tx_mix[ph];
			rx_stall_pct = rx_mix[ph];
			// long sink hold-off so a run backs up and the input stalls
			if (ph == 2)
				rx_hold = 3000;
			for (int n = 0; n < 15; n++)
				do_row(rand_row((ph == 2 && n == 0) ? 100 : 15));
			wait_idle();   // sender pauses until every result is in
		end

		// fill the table with fresh pairs until edges are dropped, then check the
		// sticky flag on runs
		write_reg(dsp_pkg::RegDirected, 0);
		tx_idle_pct = 29;
		rx_stall_pct = 29;
		guard = 0;
		while (!g_dropped && guard < 300) begin
			fill = rand_row(0);
			fill.a = 6'(12 + guard % 26);
			fill.b = 6'(38 + (guard / 26) % 26);
			do_row(fill);
			guard++;
		end
		for (int n = 0; n < 4; n++)
			do_row(rand_row(50));

		wait_idle();
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
